>>> rtl/core/fews_pkg.sv
// Shared types, codes and the sector map for the flash erase-once write sequencer.
// No dependencies; every other file of the block imports this package.
package fews_pkg;

  localparam int OP_W    = 3;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 16;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int CODE_W  = 7;
  localparam int SLOT_LIMIT = 16;
  localparam int SECT_W  = 4;
  localparam int WCNT_W  = LEN_W - 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int WORD_BYTES  = 4;

  localparam int                DEF_NUM_SECTORS     = 12;
  localparam int                DEF_MAX_WRITE_BYTES = 256;
  localparam logic [ADDR_W-1:0] DEF_FLASH_BASE_ADDR = 32'h0800_0000;

  // Sector start offsets from the flash base, in 128 KiB steps from the sixth sector on.
  localparam logic [ADDR_W-1:0] SECTOR_OFFSET [SLOT_LIMIT] = '{
    32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
    32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
    32'h0008_0000, 32'h000A_0000, 32'h000C_0000, 32'h000E_0000,
    32'h0010_0000, 32'h0012_0000, 32'h0014_0000, 32'h0016_0000
  };

  typedef enum logic [OP_W-1:0] {
    OP_WRITE         = 3'd0,
    OP_WRITE_NOERASE = 3'd1,
    OP_DATA          = 3'd2,
    OP_CLEAR         = 3'd3,
    OP_PROG_FAIL     = 3'd4
  } fews_op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REJECT  = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_ERASE   = 3'd2,
    KIND_PROGRAM = 3'd3,
    KIND_ACK     = 3'd4,
    KIND_DISCARD = 3'd5
  } fews_kind_t;

  // Classified item as it waits in the queue. The argument is the address of a
  // request or the data of a data word item.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SECT_W-1:0] sect;
    logic              pass;
    logic [WCNT_W-1:0] wcnt;
    logic [ADDR_W-1:0] arg;
  } fews_cmd_t;

  // The last sector among the first num_sectors whose start does not exceed addr.
  function automatic logic [SECT_W-1:0] fews_sector_lookup(
    input logic [ADDR_W-1:0] addr,
    input logic [ADDR_W-1:0] base,
    input int                num_sectors
  );
    logic [SECT_W-1:0] idx;
    logic [ADDR_W-1:0] off;
    idx = '0;
    off = addr - base;
    if (addr >= base) begin
      for (int i = 1; i < SLOT_LIMIT; i++) begin
        if (i < num_sectors && SECTOR_OFFSET[i] <= off) begin
          idx = SECT_W'(i);
        end
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/fews_if.sv
// Valid/ready channel interfaces for the request input and the command output.
// Depends on fews_pkg for the field widths.
interface fews_in_if;
  import fews_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [DATA_W-1:0] word_data;

  modport source (output valid, op, address, length, word_data, input ready);
  modport sink   (input valid, op, address, length, word_data, output ready);
endinterface

interface fews_out_if;
  import fews_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] sector_code;
  logic [ADDR_W-1:0] word_address;
  logic [DATA_W-1:0] program_data;
  logic              write_done;

  modport source (output valid, kind, sector_code, word_address, program_data, write_done,
                  input ready);
  modport sink   (input valid, kind, sector_code, word_address, program_data, write_done,
                  output ready);
endinterface

>>> rtl/core/fews_front.sv
// Front end: accepts input items, looks up the sector and checks write requests.
// Depends on fews_pkg and fews_in_if; feeds fews_fifo.
module fews_front #(
  parameter int                NUM_SECTORS     = fews_pkg::DEF_NUM_SECTORS,
  parameter int                MAX_WRITE_BYTES = fews_pkg::DEF_MAX_WRITE_BYTES,
  parameter logic [31:0]       FLASH_BASE_ADDR = fews_pkg::DEF_FLASH_BASE_ADDR
) (
  fews_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output fews_pkg::fews_cmd_t  q_cmd
);
  import fews_pkg::*;

  localparam logic [LEN_W:0] MAX_LEN = (LEN_W+1)'(MAX_WRITE_BYTES);

  logic len_ok;
  logic addr_ok;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign len_ok  = (in_ch.length[1:0] == 2'b00) && ({1'b0, in_ch.length} <= MAX_LEN);
  assign addr_ok = (in_ch.address >= FLASH_BASE_ADDR);

  always_comb begin
    q_cmd.op   = in_ch.op;
    q_cmd.sect = fews_sector_lookup(in_ch.address, FLASH_BASE_ADDR, NUM_SECTORS);
    q_cmd.pass = len_ok && addr_ok;
    q_cmd.wcnt = in_ch.length[LEN_W-1:2];
    // Data word items carry their word in place of an address.
    q_cmd.arg  = (in_ch.op == OP_DATA) ? in_ch.word_data : in_ch.address;
  end

endmodule

>>> rtl/core/fews_fifo.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on fews_pkg for the entry type.
module fews_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fews_pkg::fews_cmd_t push_cmd,
  input  logic                pop,
  output fews_pkg::fews_cmd_t pop_cmd,
  output logic                full,
  output logic                empty
);
  import fews_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fews_cmd_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/fews_back.sv
// Back end: holds the sector marks and the write in progress, and issues commands
// into an output register. Depends on fews_pkg and fews_out_if; fed by fews_fifo.
module fews_back #(
  parameter int NUM_SECTORS     = fews_pkg::DEF_NUM_SECTORS,
  parameter int MAX_WRITE_BYTES = fews_pkg::DEF_MAX_WRITE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  fews_pkg::fews_cmd_t q_cmd,
  output logic                q_pop,
  fews_out_if.source          out_ch
);
  import fews_pkg::*;

  localparam int IDX_W  = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
  localparam int WREM_W = $clog2(MAX_WRITE_BYTES / WORD_BYTES + 1);

  logic [NUM_SECTORS-1:0] marks_r, marks_nxt;
  logic                   active_r, active_nxt;
  logic [ADDR_W-1:0]      nwa_r, nwa_nxt;
  logic [WREM_W-1:0]      wrem_r, wrem_nxt;

  logic                   ovalid_r, ovalid_nxt;
  fews_kind_t             kind_r, kind_nxt;
  logic [CODE_W-1:0]      code_r, code_nxt;
  logic [ADDR_W-1:0]      waddr_r, waddr_nxt;
  logic [DATA_W-1:0]      pdata_r, pdata_nxt;
  logic                   done_r, done_nxt;

  logic [IDX_W-1:0]       idx;
  logic [WREM_W-1:0]      req_words;

  assign idx       = IDX_W'(q_cmd.sect);
  assign req_words = WREM_W'(q_cmd.wcnt);

  // A new command is taken whenever the output register is free or being emptied.
  assign q_pop = !q_empty && (!ovalid_r || out_ch.ready);

  always_comb begin
    marks_nxt  = marks_r;
    active_nxt = active_r;
    nwa_nxt    = nwa_r;
    wrem_nxt   = wrem_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    kind_nxt   = kind_r;
    code_nxt   = code_r;
    waddr_nxt  = waddr_r;
    pdata_nxt  = pdata_r;
    done_nxt   = done_r;
    if (q_pop) begin
      ovalid_nxt = 1'b1;
      kind_nxt   = KIND_ACK;
      code_nxt   = '0;
      waddr_nxt  = '0;
      pdata_nxt  = '0;
      done_nxt   = 1'b0;
      unique case (q_cmd.op)
        OP_WRITE, OP_WRITE_NOERASE: begin
          // The no-erase request marks its sector even if it is then rejected.
          if (q_cmd.op == OP_WRITE_NOERASE) begin
            marks_nxt[idx] = 1'b1;
          end
          active_nxt = 1'b0;
          wrem_nxt   = '0;
          if (!q_cmd.pass) begin
            kind_nxt = KIND_REJECT;
          end else begin
            if (!marks_nxt[idx]) begin
              marks_nxt[idx] = 1'b1;
              kind_nxt       = KIND_ERASE;
              code_nxt       = {q_cmd.sect, 3'b000};
            end else begin
              kind_nxt = KIND_ACCEPT;
            end
            nwa_nxt    = q_cmd.arg;
            wrem_nxt   = req_words;
            active_nxt = (req_words != '0);
          end
        end
        OP_DATA: begin
          if (!active_r) begin
            kind_nxt = KIND_DISCARD;
          end else begin
            kind_nxt  = KIND_PROGRAM;
            waddr_nxt = nwa_r;
            pdata_nxt = q_cmd.arg;
            nwa_nxt   = nwa_r + ADDR_W'(WORD_BYTES);
            wrem_nxt  = wrem_r - 1'b1;
            if (wrem_r == WREM_W'(1)) begin
              done_nxt   = 1'b1;
              active_nxt = 1'b0;
            end
          end
        end
        OP_CLEAR: begin
          marks_nxt[idx] = 1'b0;
        end
        OP_PROG_FAIL: begin
          marks_nxt  = '0;
          active_nxt = 1'b0;
          wrem_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r  <= '0;
      active_r <= 1'b0;
      nwa_r    <= '0;
      wrem_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      marks_r  <= marks_nxt;
      active_r <= active_nxt;
      nwa_r    <= nwa_nxt;
      wrem_r   <= wrem_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    code_r  <= code_nxt;
    waddr_r <= waddr_nxt;
    pdata_r <= pdata_nxt;
    done_r  <= done_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.sector_code  = code_r;
  assign out_ch.word_address = waddr_r;
  assign out_ch.program_data = pdata_r;
  assign out_ch.write_done   = done_r;

endmodule

>>> rtl/core/flash_erase_once_write_sequencer.sv
// Top level of the flash erase-once write sequencer: front end, queue, back end.
// Depends on fews_pkg, fews_if, fews_front, fews_fifo and fews_back.
//
//   Channel   Direction  Handshake      Carries
//   in_ch     input      valid/ready    op, address, length, word_data
//   out_ch    output     valid/ready    kind, sector_code, word_address,
//                                       program_data, write_done
//
// Every item gives exactly one result; it passes through the two-entry queue and then
// the output register.
// One item per cycle is sustained while the output is not stalled; the back end updates
// the sector marks and the write state as it takes each item.
// Reset (rst_n low, synchronous) clears the marks, ends any write and empties the queue.
// A stalled output holds its result; the queue keeps taking items until it is full.
module flash_erase_once_write_sequencer #(
  parameter int          NUM_SECTORS     = fews_pkg::DEF_NUM_SECTORS,
  parameter int          MAX_WRITE_BYTES = fews_pkg::DEF_MAX_WRITE_BYTES,
  parameter logic [31:0] FLASH_BASE_ADDR = fews_pkg::DEF_FLASH_BASE_ADDR
) (
  input  logic       clk,
  input  logic       rst_n,
  fews_in_if.sink    in_ch,
  fews_out_if.source out_ch
);
  import fews_pkg::*;

  fews_cmd_t push_cmd;
  fews_cmd_t pop_cmd;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  fews_front #(
    .NUM_SECTORS     (NUM_SECTORS),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES),
    .FLASH_BASE_ADDR (FLASH_BASE_ADDR)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  fews_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  fews_back #(
    .NUM_SECTORS     (NUM_SECTORS),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid)
    else $error("command taken from the queue but no result presented");

  a_stall_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !q_pop)
    else $error("queue advanced while the output was stalled");

endmodule

>>> verif/tb_flash_erase_once_write_sequencer.sv
// Self-checking testbench for the flash erase-once write sequencer. Needs fews_pkg,
// fews_if and the RTL. A directed table and then random write sequences drive the
// request channel; the table or a sector-mark predictor gives each expected command.
module tb_flash_erase_once_write_sequencer;
  import fews_pkg::*;

  localparam int          NUM_SECT      = 12;
  localparam int          MAX_BYTES     = 256;
  localparam logic [31:0] FLASH_BASE    = DEF_FLASH_BASE_ADDR;
  localparam int          RANDOM_ITEMS  = 1150;
  localparam int          QUIET_ITEMS   = 150;
  localparam int          DRAIN_CYCLES  = 8;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

  localparam logic [31:0] SECT_START [NUM_SECT] = '{
    32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
    32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
    32'h0008_0000, 32'h000A_0000, 32'h000C_0000, 32'h000E_0000
  };

  typedef struct packed {
    fews_kind_t  kind;
    logic [6:0]  code;
    logic [31:0] waddr;
    logic [31:0] pdata;
    logic        done;
  } cmd_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [15:0] len;
    logic [31:0] data;
    bit          typed;
    cmd_res_t    want;
  } stim_t;

  logic clk;
  logic rst_n;

  fews_in_if  in_ch ();
  fews_out_if out_ch ();

  flash_erase_once_write_sequencer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted block state.
  logic [NUM_SECT-1:0] sector_marks = '0;
  logic                wr_active    = 1'b0;
  logic [31:0]         next_addr    = '0;
  logic [6:0]          words_left   = '0;

  cmd_res_t expected_cmds [$];
  stim_t    pending_items [$];
  int       sent_count   = 0;
  int       results_seen = 0;
  int       errors       = 0;
  bit       quiet        = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [3:0] sector_index(input logic [31:0] addr);
    logic [3:0]  idx;
    logic [31:0] off;
    idx = '0;
    if (addr >= FLASH_BASE) begin
      off = addr - FLASH_BASE;
      for (int i = 0; i < NUM_SECT; i++) begin
        if (SECT_START[i] <= off) idx = 4'(i);
      end
    end
    return idx;
  endfunction

  // Advances the predicted state by one item and returns the command it causes.
  function automatic cmd_res_t predict_command(input logic [2:0] op, input logic [31:0] addr,
                                               input logic [15:0] len, input logic [31:0] data);
    cmd_res_t   r;
    logic [3:0] idx;
    r = '0;
    r.kind = KIND_ACK;
    case (op)
      OP_WRITE, OP_WRITE_NOERASE: begin
        idx = sector_index(addr);
        // The no-erase request marks the sector even if the check then fails.
        if (op == OP_WRITE_NOERASE) sector_marks[idx] = 1'b1;
        wr_active  = 1'b0;
        words_left = '0;
        if (len[1:0] != 2'b00 || len > MAX_BYTES || addr < FLASH_BASE) begin
          r.kind = KIND_REJECT;
        end else begin
          if (!sector_marks[idx]) begin
            sector_marks[idx] = 1'b1;
            r.kind = KIND_ERASE;
            r.code = {idx, 3'b000};
          end else begin
            r.kind = KIND_ACCEPT;
          end
          next_addr  = addr;
          words_left = len[8:2];
          wr_active  = (len[8:2] != 7'd0);
        end
      end
      OP_DATA: begin
        if (!wr_active) begin
          r.kind = KIND_DISCARD;
        end else begin
          r.kind     = KIND_PROGRAM;
          r.waddr    = next_addr;
          r.pdata    = data;
          next_addr  = next_addr + 32'd4;
          words_left = words_left - 7'd1;
          if (words_left == 7'd0) begin
            r.done    = 1'b1;
            wr_active = 1'b0;
          end
        end
      end
      OP_CLEAR: sector_marks[sector_index(addr)] = 1'b0;
      OP_PROG_FAIL: begin
        sector_marks = '0;
        wr_active    = 1'b0;
        words_left   = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_res_t res(input fews_kind_t kind, input logic [6:0] code,
                                   input logic [31:0] waddr, input logic [31:0] pdata,
                                   input logic done);
    cmd_res_t r;
    r.kind  = kind;
    r.code  = code;
    r.waddr = waddr;
    r.pdata = pdata;
    r.done  = done;
    return r;
  endfunction

  function automatic stim_t mk_item(input logic [2:0] op, input logic [31:0] addr,
                                    input logic [15:0] len, input logic [31:0] data,
                                    input bit typed, input cmd_res_t want);
    stim_t s;
    s.op    = op;
    s.addr  = addr;
    s.len   = len;
    s.data  = data;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [31:0] pick_flash_addr();
    logic [31:0] a;
    case ($urandom_range(0, 5))
      0: a = FLASH_BASE + SECT_START[$urandom_range(0, NUM_SECT - 1)];
      1: a = FLASH_BASE + SECT_START[$urandom_range(1, NUM_SECT - 1)]
             - 32'(4 * $urandom_range(1, 4));
      2: a = FLASH_BASE + 32'($urandom_range(0, 32'h0017_FFFF));
      3: a = (FLASH_BASE + 32'($urandom_range(0, 32'h0000_3FFF))) & ~32'h3;
      4: a = 32'hFFFF_FFFF - 32'($urandom_range(0, 32'hFF));
      default: a = $urandom();
    endcase
    return a;
  endfunction

  function automatic logic [15:0] pick_len();
    logic [15:0] l;
    case ($urandom_range(0, 9))
      0: l = 16'd0;
      1: l = 16'(MAX_BYTES);
      2: l = 16'(4 * $urandom_range(17, 63));
      default: l = 16'(4 * $urandom_range(1, 8));
    endcase
    return l;
  endfunction

  // Presents one item and returns at the edge where it is accepted.
  task automatic send_item(input stim_t s);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pending_items.push_back(s);
    in_ch.valid     <= 1'b1;
    in_ch.op        <= s.op;
    in_ch.address   <= s.addr;
    in_ch.length    <= s.len;
    in_ch.word_data <= s.data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (results_seen < sent_count) @(posedge clk);
  endtask

  // Result receiver with random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cmd_res_t want;
    cmd_res_t got;
    stim_t    tag;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind  = fews_kind_t'(out_ch.kind);
        got.code  = out_ch.sector_code;
        got.waddr = out_ch.word_address;
        got.pdata = out_ch.program_data;
        got.done  = out_ch.write_done;
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected command kind %0d code %0d addr %h data %h done %0b",
                   $time, got.kind, got.code, got.waddr, got.pdata, got.done);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            $display("%0t: expected kind %0d code %0d addr %h data %h done %0b", $time,
                     want.kind, want.code, want.waddr, want.pdata, want.done);
            $display("%0t:   actual kind %0d code %0d addr %h data %h done %0b", $time,
                     got.kind, got.code, got.waddr, got.pdata, got.done);
            errors++;
          end
        end
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        tag  = pending_items.pop_front();
        want = predict_command(in_ch.op, in_ch.address, in_ch.length, in_ch.word_data);
        if (tag.typed) want = tag.want;
        expected_cmds.push_back(want);
      end
    end
  end

  initial begin
    stim_t       dir_rows [$];
    logic [2:0]  wr_op;
    logic [31:0] addr;
    logic [15:0] len;
    int          nwords;
    int          cut;
    int          total;
    bit          paused;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= '0;
    in_ch.address   <= '0;
    in_ch.length    <= '0;
    in_ch.word_data <= '0;

    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE, 16'd8, '0, 1,
                               res(KIND_ERASE, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'h0000_0000, 1,
                               res(KIND_PROGRAM, 7'd0, FLASH_BASE, 32'h0000_0000, 1'b0)));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'hFFFF_FFFF, 1,
                               res(KIND_PROGRAM, 7'd0, FLASH_BASE + 32'd4, 32'hFFFF_FFFF,
                                   1'b1)));
    // No write is active any more, so the word is dropped.
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'h1234_5678, 1,
                               res(KIND_DISCARD, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE, 16'd0, '0, 1,
                               res(KIND_ACCEPT, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE, 16'd6, '0, 1,
                               res(KIND_REJECT, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE, 16'd260, '0, 1,
                               res(KIND_REJECT, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
                               res(KIND_REJECT, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE - 32'd4, 16'd4, '0, 1,
                               res(KIND_REJECT, 7'd0, '0, '0, 1'b0)));
    // An address below the base falls into sector zero for clear and no-erase.
    dir_rows.push_back(mk_item(OP_CLEAR, 32'h0000_0000, '0, '0, 1,
                               res(KIND_ACK, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE_NOERASE, 32'h0000_0000, 16'd4, '0, 1,
                               res(KIND_REJECT, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE, 16'(MAX_BYTES), '0, 1,
                               res(KIND_ACCEPT, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'hA5A5_A5A5, 0, '0));
    // A new request ends the write in progress; the top address is in the last sector.
    dir_rows.push_back(mk_item(OP_WRITE, 32'hFFFF_FFFC, 16'd8, '0, 1,
                               res(KIND_ERASE, 7'd88, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'h5A5A_5A5A, 0, '0));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'h0F0F_0F0F, 0, '0));
    dir_rows.push_back(mk_item(OP_PROG_FAIL, 32'hFFFF_FFFF, 16'hFFFF, '0, 1,
                               res(KIND_ACK, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE + 32'h000E_0000, 16'd4, '0, 1,
                               res(KIND_ERASE, 7'd88, '0, '0, 1'b0)));
    // This write crosses into the next sector, which stays unerased.
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE + 32'h0001_FFFC, 16'd8, '0, 1,
                               res(KIND_ERASE, 7'd32, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'h8000_0001, 0, '0));
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'h7FFF_FFFE, 0, '0));
    dir_rows.push_back(mk_item(OP_WRITE, FLASH_BASE + 32'h0002_0000, 16'd252, '0, 1,
                               res(KIND_ERASE, 7'd40, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_CLEAR, FLASH_BASE + 32'h0002_0000, '0, '0, 1,
                               res(KIND_ACK, 7'd0, '0, '0, 1'b0)));
    // Clearing the mark leaves the active write going.
    dir_rows.push_back(mk_item(OP_DATA, '0, '0, 32'hCAFE_F00D, 0, '0));
    dir_rows.push_back(mk_item(OP_SPARE_FIRST, FLASH_BASE, 16'd4, '0, 1,
                               res(KIND_ACK, 7'd0, '0, '0, 1'b0)));
    dir_rows.push_back(mk_item(OP_SPARE_LAST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
                               res(KIND_ACK, 7'd0, '0, '0, 1'b0)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    total  = sent_count + RANDOM_ITEMS;
    paused = 1'b0;
    while (sent_count < total) begin
      if (sent_count >= total - QUIET_ITEMS) quiet = 1'b1;
      if (!paused && sent_count >= total - RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_all_results();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          wr_op  = ($urandom_range(0, 3) == 0) ? OP_WRITE_NOERASE : OP_WRITE;
          addr   = pick_flash_addr();
          len    = pick_len();
          nwords = int'(len[15:2]);
          send_item(mk_item(wr_op, addr, len, $urandom(), 0, '0));
          // Most writes deliver exactly their words; some stop early or run over.
          if ($urandom_range(0, 7) == 0) cut = $urandom_range(0, nwords);
          else cut = nwords + (($urandom_range(0, 5) == 0) ? 1 : 0);
          for (int w = 0; w < cut; w++) begin
            if ($urandom_range(0, 31) == 0) begin
              send_item(mk_item(($urandom_range(0, 1) == 0) ? OP_CLEAR : OP_PROG_FAIL,
                                pick_flash_addr(), 16'($urandom_range(0, 16'hFFFF)),
                                $urandom(), 0, '0));
            end
            send_item(mk_item(OP_DATA, $urandom(), 16'($urandom_range(0, 16'hFFFF)),
                              $urandom(), 0, '0));
          end
        end
        6: send_item(mk_item(OP_CLEAR, pick_flash_addr(), 16'($urandom_range(0, 16'hFFFF)),
                             $urandom(), 0, '0));
        7: send_item(mk_item(OP_PROG_FAIL, $urandom(), 16'($urandom_range(0, 16'hFFFF)),
                             $urandom(), 0, '0));
        default: send_item(mk_item(3'($urandom_range(0, 7)), $urandom(),
                                   16'($urandom_range(0, 16'hFFFF)), $urandom(), 0, '0));
      endcase
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cmds.size() != 0) begin
      $display("%0t: %0d expected commands never arrived", $time, expected_cmds.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
